// ===== rtl/cbmf_pkg.sv =====
`timescale 1ns / 1ps

package cbmf_pkg;

  // Configuration port geometry.
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = CFG_AW - 2;

  // Register map, one 32-bit word per register.
  localparam logic [REG_IDX_W-1:0] REG_TARGET_IS_BLUE       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS_THRESHOLD = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_THRESHOLD      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH          = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT         = 3'd4;

  // Frame dimension registers are 12 bits; row counters need one more bit
  // because the tail runs more than two lines past the last image line.
  localparam int DIM_W = 12;
  localparam int ROW_W = DIM_W + 1;
  localparam int PIX_W = 8;

  localparam logic             RST_TARGET_IS_BLUE       = 1'b0;
  localparam logic [PIX_W-1:0] RST_BRIGHTNESS_THRESHOLD = 8'd100;
  localparam logic [PIX_W-1:0] RST_COLOR_THRESHOLD      = 8'd50;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH          = 12'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT         = 12'd480;

  // Request opcodes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Fixed-point luma: weights sum to 2^14, rounded before the shift.
  localparam int              PROD_W     = 22;
  localparam int              LUMA_SHIFT = 14;
  localparam logic [13:0]     LUMA_R     = 14'd4899;
  localparam logic [13:0]     LUMA_G     = 14'd9617;
  localparam logic [13:0]     LUMA_B     = 14'd1868;
  localparam logic [PROD_W-1:0] LUMA_ROUND = 22'd8192;

  typedef struct packed {
    logic             opcode;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } in_item_t;

  typedef struct packed {
    logic mask_bit;
    logic frame_end;
  } out_item_t;

endpackage

// ===== rtl/cbmf_line_ram.sv =====
`timescale 1ns / 1ps

module cbmf_line_ram #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 3
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Read and write share the enable. A read of the entry being written in
  // the same cycle returns the new data, so back-to-back updates of one
  // column chain correctly.
  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/color_bar_mask_filter_top.sv =====
// Color bar mask filter. Pixel requests (BGR, raster order) enter on the in_
// channel and one mask result per image pixel leaves on the out_ channel. A
// pixel is bright when its rounded fixed-point luma exceeds the brightness
// threshold and hot when the saturating color difference (blue minus red, or
// red minus blue) exceeds the color threshold. The mask is the cross-shaped
// 3x3 dilation of (cross dilation of hot AND bright); pixels outside the image
// count as zero. The block takes one request per clock, sustained: the only
// thing that stops input is a full output side (output register plus skid
// entry), and each result passes the stage 1, stage 2 and output registers
// in turn. Because the window is centered, the result of pixel p leaves
// with request p + 2*W + 2, so after the last pixel of a frame the user sends
// 2*W + 2 flush requests (pixel requests there are taken as flushes); the last
// result carries frame_end. Flushes before a frame's last pixel are dropped.
// Width and height are sampled by the first pixel of each frame, width being
// clamped to 1..MAX_WIDTH and height to at least 1; write the registers only
// while the block is idle. The window state lives in two line memories of
// MAX_WIDTH entries each, read and written back once per request; there is no
// clearing pass after reset.
`timescale 1ns / 1ps

module color_bar_mask_filter_top
  import cbmf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);

  // Stage 1 holds a request whose line memory read is returning this cycle.
  typedef struct packed {
    logic              is_pix;
    logic [COL_W-1:0]  kc;
    logic              hot;
    logic [PROD_W-1:0] prod_red;
    logic [PROD_W-1:0] prod_green;
    logic [PROD_W-1:0] prod_blue;
    logic              q_act;
    logic              q_in;
    logic              q_up;
    logic              q_dn;
    logic              q_lf;
    logic              q_rt;
    logic [COL_W-1:0]  qc;
    logic              p_in;
    logic              p_up;
    logic              p_dn;
    logic              p_lf;
    logic              p_rt;
    logic              p_last;
  } s1_t;

  // Stage 2 holds the first-stage mask bit and the output window position.
  typedef struct packed {
    logic             q_act;
    logic [COL_W-1:0] qc;
    logic             mask_q;
    logic             p_in;
    logic             p_up;
    logic             p_dn;
    logic             p_lf;
    logic             p_rt;
    logic             p_last;
  } s2_t;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic             cfg_tib_r;
  logic [PIX_W-1:0] cfg_bthr_r;
  logic [PIX_W-1:0] cfg_cthr_r;
  logic [DIM_W-1:0] cfg_width_r;
  logic [DIM_W-1:0] cfg_height_r;
  logic             cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_tib_r    <= RST_TARGET_IS_BLUE;
      cfg_bthr_r   <= RST_BRIGHTNESS_THRESHOLD;
      cfg_cthr_r   <= RST_COLOR_THRESHOLD;
      cfg_width_r  <= RST_IMAGE_WIDTH;
      cfg_height_r <= RST_IMAGE_HEIGHT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TARGET_IS_BLUE:       cfg_tib_r    <= pwdata[0];
        REG_BRIGHTNESS_THRESHOLD: cfg_bthr_r   <= pwdata[PIX_W-1:0];
        REG_COLOR_THRESHOLD:      cfg_cthr_r   <= pwdata[PIX_W-1:0];
        REG_IMAGE_WIDTH:          cfg_width_r  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:         cfg_height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_TARGET_IS_BLUE:       prdata = CFG_DW'(cfg_tib_r);
      REG_BRIGHTNESS_THRESHOLD: prdata = CFG_DW'(cfg_bthr_r);
      REG_COLOR_THRESHOLD:      prdata = CFG_DW'(cfg_cthr_r);
      REG_IMAGE_WIDTH:          prdata = CFG_DW'(cfg_width_r);
      REG_IMAGE_HEIGHT:         prdata = CFG_DW'(cfg_height_r);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame position tracking. Three counter pairs follow the incoming position
  // k, the first-stage window center q = k - W - 1 and the output center
  // p = q - W - 1. All decisions for a request are made in its accept cycle.
  // ---------------------------------------------------------------------------
  logic             en;
  logic [WID_W-1:0] w_cfg, w_cur, wm1, fw_r;
  logic [DIM_W-1:0] h_cfg, h_cur, fh_r;
  logic [ROW_W-1:0] h_ext, hm1;
  logic [COL_W-1:0] kc_r, qc_r, pc_r;
  logic [ROW_W-1:0] kr_r, qr_r, pr_r;
  logic             at_start, is_pix, ignore, adv;
  logic             q_act, q_in, p_act, p_in, p_last;
  logic             k_wrap, q_wrap, p_wrap;

  // True once the given position has passed the first W + 1 places of a frame.
  function automatic logic past_first(input logic [ROW_W-1:0] row,
                                      input logic [COL_W-1:0] col);
    past_first = (row > ROW_W'(1)) || ((row == ROW_W'(1)) && (col != '0));
  endfunction

  always_comb begin
    if (cfg_width_r == '0) begin
      w_cfg = WID_W'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_cfg = WID_W'(MAX_WIDTH);
    end else begin
      w_cfg = WID_W'(cfg_width_r);
    end
    h_cfg = (cfg_height_r == '0) ? DIM_W'(1) : cfg_height_r;
  end

  always_comb begin
    at_start = (kc_r == '0) && (kr_r == '0);
    w_cur    = at_start ? w_cfg : fw_r;
    h_cur    = at_start ? h_cfg : fh_r;
    wm1      = w_cur - WID_W'(1);
    h_ext    = ROW_W'(h_cur);
    hm1      = h_ext - ROW_W'(1);
    is_pix   = kr_r < h_ext;
    // A flush before the last pixel has arrived does nothing at all.
    ignore   = (in_data.opcode == OP_FLUSH) && is_pix;
    adv      = in_valid && en && !ignore;
    q_act    = past_first(kr_r, kc_r);
    p_act    = q_act && past_first(qr_r, qc_r);
    q_in     = q_act && (qr_r < h_ext);
    p_in     = p_act && (pr_r < h_ext);
    p_last   = p_in && (WID_W'(pc_r) == wm1) && (pr_r == hm1);
    k_wrap   = WID_W'(kc_r) == wm1;
    q_wrap   = WID_W'(qc_r) == wm1;
    p_wrap   = WID_W'(pc_r) == wm1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= '0;
      fh_r <= '0;
      kc_r <= '0;
      kr_r <= '0;
      qc_r <= '0;
      qr_r <= '0;
      pc_r <= '0;
      pr_r <= '0;
    end else if (adv) begin
      if (at_start) begin
        fw_r <= w_cur;
        fh_r <= h_cur;
      end
      if (p_last) begin
        // The frame_end result returns every counter to the frame origin.
        kc_r <= '0;
        kr_r <= '0;
        qc_r <= '0;
        qr_r <= '0;
        pc_r <= '0;
        pr_r <= '0;
      end else begin
        if (k_wrap) begin
          kc_r <= '0;
          kr_r <= kr_r + ROW_W'(1);
        end else begin
          kc_r <= kc_r + COL_W'(1);
        end
        if (q_act) begin
          if (q_wrap) begin
            qc_r <= '0;
            qr_r <= qr_r + ROW_W'(1);
          end else begin
            qc_r <= qc_r + COL_W'(1);
          end
        end
        if (p_act) begin
          if (p_wrap) begin
            pc_r <= '0;
            pr_r <= pr_r + ROW_W'(1);
          end else begin
            pc_r <= pc_r + COL_W'(1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Accept cycle: color difference, luma products and the window flags.
  // ---------------------------------------------------------------------------
  logic hot_in;
  s1_t  s1_nxt, s1_r;
  logic s1_v_r;

  always_comb begin
    if (cfg_tib_r) begin
      hot_in = (in_data.blue > in_data.red) &&
               ((in_data.blue - in_data.red) > cfg_cthr_r);
    end else begin
      hot_in = (in_data.red > in_data.blue) &&
               ((in_data.red - in_data.blue) > cfg_cthr_r);
    end
    s1_nxt.is_pix     = is_pix;
    s1_nxt.kc         = kc_r;
    s1_nxt.hot        = hot_in && is_pix;
    s1_nxt.prod_red   = PROD_W'(LUMA_R) * PROD_W'(in_data.red);
    s1_nxt.prod_green = PROD_W'(LUMA_G) * PROD_W'(in_data.green);
    s1_nxt.prod_blue  = PROD_W'(LUMA_B) * PROD_W'(in_data.blue);
    s1_nxt.q_act      = q_act;
    s1_nxt.q_in       = q_in;
    s1_nxt.q_up       = qr_r != '0;
    s1_nxt.q_dn       = qr_r < hm1;
    s1_nxt.q_lf       = qc_r != '0;
    s1_nxt.q_rt       = WID_W'(qc_r) < wm1;
    s1_nxt.qc         = qc_r;
    s1_nxt.p_in       = p_in;
    s1_nxt.p_up       = pr_r != '0;
    s1_nxt.p_dn       = pr_r < hm1;
    s1_nxt.p_lf       = pc_r != '0;
    s1_nxt.p_rt       = WID_W'(pc_r) < wm1;
    s1_nxt.p_last     = p_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the hot line memory returns, per column, the hot bits of the two
  // lines above and the bright bit of the line above. The request writes its
  // own bits back, shifting the column down by one line. Registers t1_r and
  // t2_mid_r keep the previous two columns, so the cross around q is complete.
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] luma_sum;
  logic [PIX_W-1:0]  gray;
  logic              bright;
  logic [2:0]        hot_rd;
  logic [2:0]        hot_wr;
  logic [2:0]        t1_r;
  logic              t2_mid_r;
  logic              bm_r;
  logic              mask_q;

  always_comb begin
    luma_sum = s1_r.prod_red + s1_r.prod_green + s1_r.prod_blue + LUMA_ROUND;
    gray     = luma_sum[PROD_W-1:LUMA_SHIFT];
    bright   = s1_r.is_pix && (gray > cfg_bthr_r);
    hot_wr   = {s1_r.hot, hot_rd[2], bright};
    // hot_rd: [2] line above, [1] two lines above, [0] bright of line above.
    mask_q   = s1_r.q_in && bm_r &&
               (t1_r[1] || (s1_r.q_up && t1_r[0]) || (s1_r.q_dn && t1_r[2]) ||
                (s1_r.q_lf && t2_mid_r) || (s1_r.q_rt && hot_rd[2]));
  end

  cbmf_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (3)
  ) u_hot_ram (
    .clk     (clk),
    .en      (en),
    .rd_addr (kc_r),
    .rd_data (hot_rd),
    .wr_en   (s1_v_r),
    .wr_addr (s1_r.kc),
    .wr_data (hot_wr)
  );

  always_ff @(posedge clk) begin
    if (en && s1_v_r) begin
      t1_r     <= {s1_r.hot, hot_rd[2], hot_rd[1]};
      t2_mid_r <= t1_r[1];
      bm_r     <= hot_rd[0];
    end
  end

  s2_t  s2_r;
  logic s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_v_r) begin
      s2_r.q_act  <= s1_r.q_act;
      s2_r.qc     <= s1_r.qc;
      s2_r.mask_q <= mask_q;
      s2_r.p_in   <= s1_r.p_in;
      s2_r.p_up   <= s1_r.p_up;
      s2_r.p_dn   <= s1_r.p_dn;
      s2_r.p_lf   <= s1_r.p_lf;
      s2_r.p_rt   <= s1_r.p_rt;
      s2_r.p_last <= s1_r.p_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the same column scheme on the first-stage mask, addressed by the
  // column of q, gives the second dilation around p.
  // ---------------------------------------------------------------------------
  logic [1:0] mask_rd;
  logic [1:0] mask_wr;
  logic [2:0] m1_r;
  logic       m2_mid_r;
  out_item_t  res;
  logic       res_v;

  assign mask_wr = {s2_r.mask_q, mask_rd[1]};

  cbmf_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2)
  ) u_mask_ram (
    .clk     (clk),
    .en      (en),
    .rd_addr (s1_r.qc),
    .rd_data (mask_rd),
    .wr_en   (s2_v_r && s2_r.q_act),
    .wr_addr (s2_r.qc),
    .wr_data (mask_wr)
  );

  always_ff @(posedge clk) begin
    if (en && s2_v_r && s2_r.q_act) begin
      m1_r     <= {s2_r.mask_q, mask_rd[1], mask_rd[0]};
      m2_mid_r <= m1_r[1];
    end
  end

  always_comb begin
    res.mask_bit  = m1_r[1] || (s2_r.p_up && m1_r[0]) || (s2_r.p_dn && m1_r[2]) ||
                    (s2_r.p_lf && m2_mid_r) || (s2_r.p_rt && mask_rd[1]);
    res.frame_end = s2_r.p_last;
    res_v         = s2_v_r && s2_r.p_in;
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry. The pipeline advances whenever the
  // skid entry is free, so a waiting result does not stop input.
  // ---------------------------------------------------------------------------
  logic      out_v_r, skid_v_r;
  logic      out_v_nxt, skid_v_nxt;
  logic      out_load, skid_load, skid_to_out;
  out_item_t out_r, skid_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  always_comb begin
    out_v_nxt   = out_v_r;
    skid_v_nxt  = skid_v_r;
    out_load    = 1'b0;
    skid_load   = 1'b0;
    skid_to_out = 1'b0;
    if (skid_v_r) begin
      if (out_ready) begin
        skid_to_out = 1'b1;
        skid_v_nxt  = 1'b0;
      end
    end else if (res_v) begin
      if (!out_v_r || out_ready) begin
        out_load  = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        skid_load  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_to_out) begin
      out_r <= skid_r;
    end else if (out_load) begin
      out_r <= res;
    end
    if (skid_load) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds a result while the output register is empty");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res_v) |=> out_v_r)
    else $error("a finished result was not registered for output");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(s1_v_r) && $stable(s2_v_r)))
    else $error("pipeline stage moved while the output side was full");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && p_last) |=> ((kc_r == '0) && (kr_r == '0) && (qc_r == '0) &&
                         (qr_r == '0) && (pc_r == '0) && (pr_r == '0)))
    else $error("position counters did not return to origin after frame end");

  a_output_lags_center: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_r.p_in) |-> s2_r.q_act)
    else $error("output window active before the first-stage window");

endmodule

// ===== sim/color_bar_mask_filter_top_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the color bar mask filter.
//
// Pixel requests go in on the in_ channel and mask results come back on the
// out_ channel. Every request the block accepts is fed to a local predictor.
// The predictor keeps its own copy of the registers, the frame position and the
// three bit rings that the window needs. It pushes the mask result that the
// request completes, if there is one, onto a queue. Every result the block
// hands out is compared field by field with the oldest entry of that queue.
//
// The run is a chain of test tasks called from one initial block:
//   - register access: reset values, extreme writes and readback;
//   - a short directed 3x3 frame: extreme colors, threshold edges, a flush
//     before any frame, a flush inside the frame and a pixel in the tail;
//   - geometry clamps: width and height of zero, width above the maximum,
//     and a one-pixel-wide frame of full register height;
//   - random traffic in three phases of idling: first the receiver stalls
//     more than the sender idles, then the other way round, then neither does.
// Registers are only written while the block is drained.
module color_bar_mask_filter_top_tb;
  import cbmf_pkg::*;

  localparam int MAX_WIDTH    = 2048;
  localparam int RING_SIZE    = 4 * MAX_WIDTH;
  localparam int CYCLE_LIMIT  = 600_000;
  localparam int SETTLE_TICKS = 10;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  color_bar_mask_filter_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Idling knobs, in percent per cycle. The test tasks change them per phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Bookkeeping for the summary and the verdict.
  int unsigned errors;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned frames_done;
  int unsigned reg_checks;
  int unsigned workload_items;
  int unsigned cycle_count;

  // Local copy of the register file, as the predictor sees it.
  logic             cfg_blue;
  logic [PIX_W-1:0] cfg_bright_thr;
  logic [PIX_W-1:0] cfg_color_thr;
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;

  // Predictor state: frame position of the next request, the geometry latched
  // by the first pixel of the frame, and the three bit rings.
  int unsigned pos_col;
  int unsigned pos_row;
  int unsigned frame_w;
  int unsigned frame_h;
  bit          hot_ring    [RING_SIZE];
  bit          bright_ring [RING_SIZE];
  bit          mask_ring   [RING_SIZE];

  out_item_t   expected_masks[$];
  out_item_t   oldest_mask;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit ring_bit(input bit from_mask, input int unsigned pos);
    return from_mask ? mask_ring[pos % RING_SIZE] : hot_ring[pos % RING_SIZE];
  endfunction

  // Cross-shaped dilation around one pixel. Neighbors that fall outside the
  // image contribute nothing.
  function automatic bit dilate_cross(input bit from_mask, input int unsigned pos,
                                      input int unsigned w, input int unsigned h);
    int unsigned row;
    int unsigned col;
    bit          v;
    row = pos / w;
    col = pos % w;
    v = ring_bit(from_mask, pos);
    if (row > 0) v |= ring_bit(from_mask, pos - w);
    if (row + 1 < h) v |= ring_bit(from_mask, pos + w);
    if (col > 0) v |= ring_bit(from_mask, pos - 1);
    if (col + 1 < w) v |= ring_bit(from_mask, pos + 1);
    return v;
  endfunction

  // Advances the predictor by one accepted request and queues the mask result
  // that this request completes, if any.
  function automatic void predict_mask(input in_item_t req);
    bit          is_flush;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned k;
    int unsigned q;
    int unsigned p;
    int unsigned gray;
    int unsigned diff;
    out_item_t   res;
    is_flush = (req.opcode == OP_FLUSH);
    // The first pixel of a frame latches the geometry. A flush here is dropped.
    if (pos_row == 0 && pos_col == 0) begin
      if (is_flush) return;
      w = cfg_width;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = cfg_height;
      if (h < 1) h = 1;
      frame_w = w;
      frame_h = h;
    end
    w = frame_w;
    h = frame_h;
    n = w * h;
    k = pos_row * w + pos_col;

    if (k < n) begin
      // Inside the image a flush changes nothing.
      if (is_flush) return;
      gray = (32'(LUMA_R) * req.red + 32'(LUMA_G) * req.green + 32'(LUMA_B) * req.blue
              + 32'(LUMA_ROUND)) >> LUMA_SHIFT;
      if (cfg_blue) diff = (req.blue > req.red) ? req.blue - req.red : 0;
      else          diff = (req.red > req.blue) ? req.red - req.blue : 0;
      hot_ring[k % RING_SIZE]    = (diff > cfg_color_thr);
      bright_ring[k % RING_SIZE] = (gray > cfg_bright_thr);
    end

    // First stage lags one line and one pixel.
    if (k >= w + 1) begin
      q = k - w - 1;
      if (q < n) mask_ring[q % RING_SIZE] = dilate_cross(1'b0, q, w, h) & bright_ring[q % RING_SIZE];
    end

    // Second stage lags another line and pixel and produces the result.
    if (k >= 2 * w + 2) begin
      p = k - 2 * w - 2;
      if (p < n) begin
        res.mask_bit  = dilate_cross(1'b1, p, w, h);
        res.frame_end = (p + 1 == n);
        expected_masks.push_back(res);
        if (p + 1 == n) begin
          pos_col = 0;
          pos_row = 0;
          return;
        end
      end
    end

    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction and checking share one clocked process, so that a request is
  // always predicted before any result is compared at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_mask(in_data);
    if (rst_n && out_valid && out_ready) begin
      if (expected_masks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, mask_bit %0b frame_end %0b", $time,
                 out_data.mask_bit, out_data.frame_end);
      end else begin
        oldest_mask = expected_masks.pop_front();
        results_checked++;
        if (out_data.frame_end) frames_done++;
        if (out_data.mask_bit !== oldest_mask.mask_bit) begin
          errors++;
          $display("%0t: mask_bit expected %0b, actual %0b", $time,
                   oldest_mask.mask_bit, out_data.mask_bit);
        end
        if (out_data.frame_end !== oldest_mask.frame_end) begin
          errors++;
          $display("%0t: frame_end expected %0b, actual %0b", $time,
                   oldest_mask.frame_end, out_data.frame_end);
        end
      end
    end
  end

  // The receiver stalls at random, one decision per cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time,
               expected_masks.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  // One APB transfer: a setup phase, then an access phase that completes on
  // pready. Entered and left at a falling edge, with the bus idle again behind it.
  task automatic apb_access(input bit is_write, input logic [REG_IDX_W-1:0] idx,
                            input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] want);
    logic [CFG_DW-1:0] got;
    apb_access(1'b0, idx, '0, got);
    reg_checks++;
    if (got !== want) begin
      errors++;
      $display("%0t: register %0d readback expected %0h, actual %0h", $time, idx, want, got);
    end
  endtask

  // Writes a register, mirrors it into the predictor's copy and reads it back.
  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    logic [CFG_DW-1:0] dummy;
    logic [CFG_DW-1:0] held;
    case (idx)
      REG_TARGET_IS_BLUE: begin
        cfg_blue = value[0];
        held = CFG_DW'(cfg_blue);
      end
      REG_BRIGHTNESS_THRESHOLD: begin
        cfg_bright_thr = value[PIX_W-1:0];
        held = CFG_DW'(cfg_bright_thr);
      end
      REG_COLOR_THRESHOLD: begin
        cfg_color_thr = value[PIX_W-1:0];
        held = CFG_DW'(cfg_color_thr);
      end
      REG_IMAGE_WIDTH: begin
        cfg_width = value[DIM_W-1:0];
        held = CFG_DW'(cfg_width);
      end
      default: begin
        cfg_height = value[DIM_W-1:0];
        held = CFG_DW'(cfg_height);
      end
    endcase
    apb_access(1'b1, idx, held, dummy);
    check_reg(idx, held);
  endtask

  task automatic set_setup(input bit blue, input int unsigned bright, input int unsigned color,
                           input int unsigned width, input int unsigned height);
    set_reg(REG_TARGET_IS_BLUE, blue);
    set_reg(REG_BRIGHTNESS_THRESHOLD, bright);
    set_reg(REG_COLOR_THRESHOLD, color);
    set_reg(REG_IMAGE_WIDTH, width);
    set_reg(REG_IMAGE_HEIGHT, height);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic in_item_t pixel_of(input int unsigned b, input int unsigned g,
                                        input int unsigned r);
    in_item_t item;
    item.opcode = OP_PIXEL;
    item.blue   = b[PIX_W-1:0];
    item.green  = g[PIX_W-1:0];
    item.red    = r[PIX_W-1:0];
    return item;
  endfunction

  // A flush carries random channel bits, which the block must ignore.
  function automatic in_item_t flush_item();
    in_item_t item;
    item = pixel_of($urandom_range(255), $urandom_range(255), $urandom_range(255));
    item.opcode = OP_FLUSH;
    return item;
  endfunction

  // Half of the random pixels lean toward the target color, so that hot and
  // bright pixels cluster often enough to survive both dilations.
  function automatic in_item_t random_pixel();
    int unsigned strong_ch;
    int unsigned weak_ch;
    if ($urandom_range(1)) begin
      return pixel_of($urandom_range(255), $urandom_range(255), $urandom_range(255));
    end
    strong_ch = $urandom_range(255, 150);
    weak_ch   = $urandom_range(80);
    if (cfg_blue) return pixel_of(strong_ch, $urandom_range(255), weak_ch);
    return pixel_of(weak_ch, $urandom_range(255), strong_ch);
  endfunction

  // Sends one request. Entered at a falling edge; returns at the falling edge
  // after acceptance with valid still high, so back-to-back requests need no
  // gap. Callers that pause lower valid through drain_results.
  task automatic send_request(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted result has come out, then
  // lets the pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_masks.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // Sends one complete frame for the current register setting: all pixels,
  // then the 2*W + 2 tail requests that push the last results out. noise_pct
  // sprinkles ignored flushes in front of pixels; pause_mid makes the sender
  // wait halfway until everything predicted so far has been delivered.
  task automatic run_frame(input int unsigned noise_pct, input bit pause_mid);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
    h = (cfg_height == 0) ? 1 : cfg_height;
    n = w * h;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) send_request(flush_item());
      if (pause_mid && i == n / 2) drain_results();
      send_request(random_pixel());
    end
    // In the tail a pixel request counts as a flush and its data is dropped.
    for (int unsigned i = 0; i < 2 * w + 2; i++) begin
      if ($urandom_range(99) < 30) send_request(random_pixel());
      else send_request(flush_item());
    end
    workload_items += n + 2 * w + 2;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_register_access();
    check_reg(REG_TARGET_IS_BLUE, CFG_DW'(RST_TARGET_IS_BLUE));
    check_reg(REG_BRIGHTNESS_THRESHOLD, CFG_DW'(RST_BRIGHTNESS_THRESHOLD));
    check_reg(REG_COLOR_THRESHOLD, CFG_DW'(RST_COLOR_THRESHOLD));
    check_reg(REG_IMAGE_WIDTH, CFG_DW'(RST_IMAGE_WIDTH));
    check_reg(REG_IMAGE_HEIGHT, CFG_DW'(RST_IMAGE_HEIGHT));
    // Every bit of every register both ways.
    set_setup(1, 255, 255, 4095, 4095);
    set_setup(0, 0, 0, 0, 0);
  endtask

  // A 3x3 frame aimed at red with hand-picked pixels around the thresholds.
  task automatic test_directed_frame();
    send_idle_pct  = 27;
    recv_stall_pct = 70;
    set_setup(0, 60, 40, 3, 3);
    // Before any frame has started a flush is ignored.
    send_request(flush_item());
    send_request(pixel_of(0, 0, 0));
    send_request(pixel_of(255, 255, 255));
    send_request(pixel_of(0, 0, 255));
    send_request(pixel_of(255, 0, 0));
    // A flush in the middle of the frame is ignored too.
    send_request(flush_item());
    send_request(pixel_of(0, 255, 0));
    send_request(pixel_of(40, 90, 200));
    send_request(pixel_of(255, 0, 255));
    // Differences just above and exactly at the color threshold.
    send_request(pixel_of(0, 0, 41));
    send_request(pixel_of(0, 0, 40));
    // Tail: a pixel here acts as a flush.
    send_request(flush_item());
    send_request(pixel_of(0, 0, 255));
    for (int i = 0; i < 6; i++) send_request(flush_item());
    workload_items += 17;
    drain_results();
  endtask

  // Register values outside the usable geometry range, and the largest frames.
  task automatic test_geometry_clamps();
    send_idle_pct  = 5;
    recv_stall_pct = 5;
    // Width and height of zero: a single-pixel frame.
    set_setup(1, 0, 0, 0, 0);
    run_frame(0, 1'b0);
    drain_results();
    // Width above the maximum saturates to the maximum.
    set_setup(0, 0, 128, 4095, 1);
    run_frame(0, 1'b0);
    drain_results();
    // One pixel wide, the full height register, thresholds at the top.
    set_setup(1, 255, 255, 1, 4095);
    run_frame(0, 1'b0);
    drain_results();
  endtask

  task automatic random_setup();
    int unsigned bright;
    int unsigned color;
    case ($urandom_range(3))
      0:       bright = 0;
      1:       bright = 255;
      default: bright = $urandom_range(160);
    endcase
    case ($urandom_range(3))
      0:       color = 0;
      1:       color = 255;
      default: color = $urandom_range(140);
    endcase
    set_setup($urandom_range(1), bright, color, $urandom_range(10), $urandom_range(6));
  endtask

  // Frames with random geometry and content. Half of the frames follow the
  // previous one without a pause, so a new frame starts while the old tail is
  // still in the pipeline.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned budget);
    int unsigned start_items;
    bit          first;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_items    = workload_items;
    first          = 1'b1;
    while (workload_items - start_items < budget) begin
      if (first || $urandom_range(1)) begin
        drain_results();
        random_setup();
      end
      run_frame(5, first || ($urandom_range(5) == 0));
      first = 1'b0;
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errors         = 0;
    requests_sent  = 0;
    results_checked = 0;
    frames_done    = 0;
    reg_checks     = 0;
    workload_items = 0;
    cycle_count    = 0;
    cfg_blue       = RST_TARGET_IS_BLUE;
    cfg_bright_thr = RST_BRIGHTNESS_THRESHOLD;
    cfg_color_thr  = RST_COLOR_THRESHOLD;
    cfg_width      = RST_IMAGE_WIDTH;
    cfg_height     = RST_IMAGE_HEIGHT;
    pos_col        = 0;
    pos_row        = 0;
    frame_w        = 0;
    frame_h        = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_directed_frame();
    test_geometry_clamps();
    test_random_traffic(27, 70, 170);
    test_random_traffic(70, 27, 170);
    test_random_traffic(0, 0, 170);

    // All stimulus is in; make sure nothing is still on its way.
    drain_results();

    $display("Sent %0d requests over %0d complete frames, including clamped geometry.",
             requests_sent, frames_done);
    $display("Compared %0d mask results and %0d register readbacks.",
             results_checked, reg_checks);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
